@@ hw/rtl/symmetric_sparse_csc_element_store_defines.svh @@
// Assertion macros used by the sparse store top level.
`ifndef SYMMETRIC_SPARSE_CSC_ELEMENT_STORE_DEFINES_SVH
`define SYMMETRIC_SPARSE_CSC_ELEMENT_STORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SSCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sparse store check failed");

// Next-cycle implication, checked out of reset.
`define SSCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sparse store check failed");

`endif

@@ hw/rtl/sscs_pkg.sv @@
// Shared types, op codes and constants of the sparse symmetric store.
package sscs_pkg;

  localparam int DEF_MAX_DIM     = 1024;
  localparam int DEF_MAX_ENTRIES = 65536;
  localparam int PTR_W           = 17;
  localparam int ROW_W           = 11;
  localparam int IDX_W           = 10;
  localparam int ADDR_W          = 16;
  localparam int VAL_W           = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [2:0] OP_WPTR  = 3'd0;
  localparam logic [2:0] OP_WIDX  = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_SET   = 3'd3;
  localparam logic [2:0] OP_GET   = 3'd4;
  localparam logic [2:0] OP_CHECK = 3'd5;
  localparam logic [2:0] OP_ZERO  = 3'd6;

  localparam logic CFG_INDEX_BASE  = 1'b0;
  localparam logic CFG_ENTRY_COUNT = 1'b1;

  // Classified request as it travels from front to back.
  typedef struct packed {
    logic [2:0]        op;
    logic              skip;
    logic [IDX_W-1:0]  hi;
    logic [IDX_W-1:0]  lo;
    logic [ADDR_W-1:0] address;
    logic [PTR_W-1:0]  entry;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ hw/rtl/sscs_front.sv @@
// Front end: takes requests and resolves triangle mirroring and skips.
module sscs_front import sscs_pkg::*; (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               op_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic [ADDR_W-1:0]        address_i,
  input  logic [PTR_W-1:0]         entry_i,
  input  logic signed [VAL_W-1:0]  value_i,
  input  queue_status_t            q_status_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = op_i;
    cmd_o.address = address_i;
    cmd_o.entry   = entry_i;
    cmd_o.value   = value_i;
    case (op_i)
      OP_ADD: begin
        // add swaps row and column
        cmd_o.skip = row_i > col_i;
        cmd_o.hi   = col_i;
        cmd_o.lo   = row_i;
      end
      OP_SET: begin
        cmd_o.skip = col_i > row_i;
        cmd_o.hi   = row_i;
        cmd_o.lo   = col_i;
      end
      default: begin
        cmd_o.skip = 1'b0;
        cmd_o.hi   = (row_i < col_i) ? col_i : row_i;
        cmd_o.lo   = (row_i < col_i) ? row_i : col_i;
      end
    endcase
  end

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule

@@ hw/rtl/sscs_queue.sv @@
// Two-entry request queue between front and back.
module sscs_queue import sscs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          cmd_i,
  input  logic          pop_i,
  output cmd_t          cmd_o,
  output queue_status_t status_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  assign cmd_o          = mem_q[rd_q];
  assign status_o.full  = 32'(cnt_q) == QUEUE_DEPTH;
  assign status_o.empty = cnt_q == '0;

endmodule

@@ hw/rtl/sscs_back.sv @@
// Back end: sequencer that owns the pointer, row and value memories.
module sscs_back import sscs_pkg::*; #(
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     index_base_i,
  input  logic [PTR_W-1:0]         entry_count_i,
  input  queue_status_t            q_status_i,
  input  cmd_t                     cmd_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [VAL_W-1:0]  read_value_o,
  output logic                     found_o,
  output logic                     not_found_error_o
);

  localparam int CS_AW  = $clog2(MAX_DIM + 1);
  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int SLOT_W = ((AW > PTR_W) ? AW : PTR_W) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_P0   = 4'd2;
  localparam logic [3:0] S_P1   = 4'd3;
  localparam logic [3:0] S_SRD  = 4'd4;
  localparam logic [3:0] S_SCMP = 4'd5;
  localparam logic [3:0] S_VRD  = 4'd6;
  localparam logic [3:0] S_ZERO = 4'd7;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] s;
    s = a + b;
    if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1]) begin
      s = a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return s;
  endfunction

  logic [PTR_W-1:0] cs_mem [MAX_DIM + 1];
  logic [ROW_W-1:0] ri_mem [MAX_ENTRIES];
  logic [VAL_W-1:0] vs_mem [MAX_ENTRIES];

  logic [3:0]        state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [PTR_W-1:0]  start_q, start_d;
  logic [SLOT_W-1:0] p_q, p_d, end_q, end_d;

  logic              cs_we, ri_we, vs_we;
  logic [CS_AW-1:0]  cs_waddr, cs_raddr;
  logic [AW-1:0]     ri_waddr, vs_addr_w, ri_raddr, vs_raddr;
  logic [VAL_W-1:0]  vs_wdata;
  logic [PTR_W-1:0]  cs_rdata_q;
  logic [ROW_W-1:0]  ri_rdata_q;
  logic [VAL_W-1:0]  vs_rdata_q;

  logic              res_en;
  logic [VAL_W-1:0]  res_val;
  logic              res_fnd, res_err;
  logic              out_valid_q;
  logic [VAL_W-1:0]  rv_q;
  logic              fnd_q, err_q;

  logic [31:0]       addr32, lo32, lo1_32;
  logic [ROW_W-1:0]  want;
  logic              is_mod;
  logic [SLOT_W-1:0] start_s, next_s, base_s, lo_p, end_raw, end_c, lim, max_s;

  assign addr32 = 32'(cmd_q.address);
  assign lo32   = 32'(cmd_q.lo);
  assign lo1_32 = lo32 + 32'd1;
  assign want   = ROW_W'(cmd_q.hi) + ROW_W'(index_base_i);
  assign is_mod = cmd_q.op == OP_ADD || cmd_q.op == OP_SET;

  assign start_s = SLOT_W'(start_q);
  assign next_s  = SLOT_W'(cs_rdata_q);
  assign base_s  = SLOT_W'(index_base_i);
  assign max_s   = SLOT_W'(MAX_ENTRIES);
  assign lo_p    = (start_s == '0) ? '0 : start_s - base_s;
  assign end_raw = next_s - base_s;
  assign end_c   = (end_raw > max_s) ? max_s : end_raw;
  assign lim     = (SLOT_W'(entry_count_i) > max_s) ? max_s : SLOT_W'(entry_count_i);

  assign pop_o = state_q == S_IDLE && !q_status_i.empty && !out_valid_q;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    start_d   = start_q;
    p_d       = p_q;
    end_d     = end_q;
    cs_we     = 1'b0;
    ri_we     = 1'b0;
    vs_we     = 1'b0;
    cs_waddr  = addr32[CS_AW-1:0];
    ri_waddr  = addr32[AW-1:0];
    vs_addr_w = p_q[AW-1:0];
    vs_wdata  = cmd_q.value;
    cs_raddr  = lo32[CS_AW-1:0];
    ri_raddr  = p_q[AW-1:0];
    vs_raddr  = p_q[AW-1:0];
    res_en    = 1'b0;
    res_val   = '0;
    res_fnd   = 1'b0;
    res_err   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          cmd_d   = cmd_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_q.op)
          OP_WPTR: begin
            cs_we   = addr32 <= 32'(MAX_DIM);
            res_en  = 1'b1;
            state_d = S_IDLE;
          end
          OP_WIDX: begin
            ri_we   = addr32 < 32'(MAX_ENTRIES);
            res_en  = 1'b1;
            state_d = S_IDLE;
          end
          OP_ZERO: begin
            p_d     = '0;
            state_d = S_ZERO;
          end
          OP_ADD, OP_SET, OP_GET, OP_CHECK: begin
            if (cmd_q.skip) begin
              res_en  = 1'b1;
              state_d = S_IDLE;
            end else if (lo32 >= 32'(MAX_DIM)) begin
              res_en  = 1'b1;
              res_err = is_mod;
              state_d = S_IDLE;
            end else begin
              state_d = S_P0;
            end
          end
          default: begin
            res_en  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_P0: begin
        start_d  = cs_rdata_q;
        cs_raddr = lo1_32[CS_AW-1:0];
        state_d  = S_P1;
      end
      S_P1: begin
        if (next_s <= start_s || lo_p >= end_c) begin
          res_en  = 1'b1;
          res_err = is_mod;
          state_d = S_IDLE;
        end else begin
          p_d     = lo_p;
          end_d   = end_c;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (ri_rdata_q == want) begin
          if (cmd_q.op == OP_SET) begin
            vs_we   = 1'b1;
            res_en  = 1'b1;
            res_fnd = 1'b1;
            state_d = S_IDLE;
          end else if (cmd_q.op == OP_CHECK) begin
            res_en  = 1'b1;
            res_fnd = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_VRD;
          end
        end else if (p_q + 1'b1 >= end_q) begin
          res_en  = 1'b1;
          res_err = is_mod;
          state_d = S_IDLE;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_VRD: begin
        res_en  = 1'b1;
        res_fnd = 1'b1;
        if (cmd_q.op == OP_ADD) begin
          vs_we    = 1'b1;
          vs_wdata = sat_add(vs_rdata_q, cmd_q.value);
        end else begin
          res_val = vs_rdata_q;
        end
        state_d = S_IDLE;
      end
      S_ZERO: begin
        if (p_q < lim) begin
          vs_we    = 1'b1;
          vs_wdata = '0;
          p_d      = p_q + 1'b1;
        end else begin
          res_en  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    start_q <= start_d;
    p_q     <= p_d;
    end_q   <= end_d;
    if (res_en) begin
      rv_q  <= res_val;
      fnd_q <= res_fnd;
      err_q <= res_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) begin
      cs_mem[cs_waddr] <= cmd_q.entry;
    end
    cs_rdata_q <= cs_mem[cs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ri_we) begin
      ri_mem[ri_waddr] <= cmd_q.entry[ROW_W-1:0];
    end
    ri_rdata_q <= ri_mem[ri_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vs_we) begin
      vs_mem[vs_addr_w] <= vs_wdata;
    end
    vs_rdata_q <= vs_mem[vs_raddr];
  end

  assign out_valid_o       = out_valid_q;
  assign read_value_o      = rv_q;
  assign found_o           = fnd_q;
  assign not_found_error_o = err_q;

endmodule

@@ hw/rtl/symmetric_sparse_csc_element_store.sv @@
// Top level of the lower-triangle sparse symmetric matrix store.
// Holds a symmetric sparse matrix as its lower triangle in compressed-column
// form (column pointers, row indices, Q32.32 values) in on-chip memories.
// Requests are write pointer, write index, add (saturating), set, get, check
// and zero; each request yields exactly one response. A two-entry queue sits
// between the request side and the sequencer, so requests keep being taken
// while a response waits. After the sequencer pops a request it dispatches it:
// pointer and index writes, skipped adds and sets, and unused codes respond
// from the dispatch state; a search reads the two column pointers and then
// visits the stored rows of the column (one row-index memory read and compare
// each), and get or add then read the value memory; zero clears
// min(entry_count, MAX_ENTRIES) value slots, one slot per cycle. The next request
// is popped only once the previous response has been taken. Memory contents are
// undefined after reset until loaded; index_base and entry_count must be written
// on the cfg port only while idle, which the block itself does not enforce.
`include "symmetric_sparse_csc_element_store_defines.svh"

module symmetric_sparse_csc_element_store import sscs_pkg::*; #(
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [PTR_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               op_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic [ADDR_W-1:0]        address_i,
  input  logic [PTR_W-1:0]         entry_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [VAL_W-1:0]  read_value_o,
  output logic                     found_o,
  output logic                     not_found_error_o
);

  // config registers
  logic             index_base_q;
  logic [PTR_W-1:0] entry_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_base_q  <= 1'b0;
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INDEX_BASE:  index_base_q  <= cfg_data_i[0];
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  queue_status_t q_status;
  cmd_t          push_cmd, head_cmd;
  logic          push, pop;

  sscs_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .address_i  (address_i),
    .entry_i    (entry_i),
    .value_i    (value_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  sscs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  sscs_back #(
    .MAX_DIM     (MAX_DIM),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .index_base_i      (index_base_q),
    .entry_count_i     (entry_count_q),
    .q_status_i        (q_status),
    .cmd_i             (head_cmd),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .read_value_o      (read_value_o),
    .found_o           (found_o),
    .not_found_error_o (not_found_error_o)
  );

  // a response never claims both a hit and a miss
  `SSCS_ASSERT_IMP(a_flags_excl, clk_i, rst_ni, out_valid_o, !(found_o && not_found_error_o))
  // only a hit can carry a nonzero value
  `SSCS_ASSERT_IMP(a_value_hit, clk_i, rst_ni, out_valid_o && read_value_o != '0, found_o)
  // queue is never popped while empty
  `SSCS_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop, !q_status.empty)
  // a full queue admits nothing that cycle
  `SSCS_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, q_status.full, !push)

endmodule
